// File: src/rita_pkg.sv
// Shared constants, types and helper functions for the integer-to-ASCII converter.
package rita_pkg;

   localparam int VALUE_BITS     = 64;
   localparam int NARROW_BITS    = 32;
   localparam int REQ_DATA_BITS  = ((VALUE_BITS + 7) / 8) * 8;
   localparam int BITS_PER_STAGE = 4;
   localparam int DABBLE_STAGES  = (VALUE_BITS + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
   localparam int WORK_BITS      = DABBLE_STAGES * BITS_PER_STAGE;
   localparam int BCD_DIGITS     = (VALUE_BITS * 30103) / 100000 + 1;
   localparam int BCD_BITS       = BCD_DIGITS * 4;
   localparam int OCT_DIGITS     = (VALUE_BITS + 2) / 3;
   localparam int HEX_DIGITS     = (VALUE_BITS + 3) / 4;
   localparam int MAX_DIGITS     = OCT_DIGITS;
   localparam int IDX_BITS       = $clog2(MAX_DIGITS);

   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_ALPHA = 8'h57;  // 'a' minus ten

   typedef enum logic [1:0] {
      RADIX_DEC  = 2'd0,
      RADIX_HEX  = 2'd1,
      RADIX_OCT  = 2'd2,
      RADIX_RSVD = 2'd3
   } radix_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] raw;
      logic [WORK_BITS-1:0]  work;
      logic [BCD_BITS-1:0]   bcd;
      radix_type             radix;
      logic                  neg;
   } pipe_type;

   typedef struct packed {
      logic [MAX_DIGITS-1:0][3:0] digits;
      logic [IDX_BITS-1:0]        top;
      logic                       neg;
   } number_type;

   // Several double-dabble iterations: add 3 to digits >= 5, then shift one bit in.
   function automatic pipe_type dabble_step(pipe_type p);
      pipe_type q;
      q = p;
      for (int s = 0; s < BITS_PER_STAGE; s++) begin
         for (int d = 0; d < BCD_DIGITS; d++) begin
            if (q.bcd[d*4 +: 4] >= 4'd5) begin
               q.bcd[d*4 +: 4] = q.bcd[d*4 +: 4] + 4'd3;
            end
         end
         q.bcd  = {q.bcd[BCD_BITS-2:0], q.work[WORK_BITS-1]};
         q.work = {q.work[WORK_BITS-2:0], 1'b0};
      end
      return q;
   endfunction

   function automatic logic [7:0] digit_char(logic [3:0] d);
      logic [7:0] c;
      if (d < 4'd10) begin
         c = CHAR_ZERO + {4'h0, d};
      end else begin
         c = CHAR_ALPHA + {4'h0, d};
      end
      return c;
   endfunction

endpackage

// File: src/rita_serializer.sv
// Character serializer: emits sign and digits of one number, most significant first.
module rita_serializer import rita_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       num_valid,
   input  number_type num,
   output logic       num_ready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic       rsp_tlast
);

   logic                       busy_ff;
   logic                       neg_ff;
   logic [IDX_BITS-1:0]        idx_ff;
   logic [MAX_DIGITS-1:0][3:0] digits_ff;
   logic                       out_valid_ff;
   logic [7:0]                 out_char_ff;
   logic                       out_last_ff;
   logic                       out_free;
   logic                       emit;
   logic                       load;

   assign out_free  = !out_valid_ff || rsp_tready;
   assign emit      = busy_ff && out_free;
   assign num_ready = !busy_ff;
   assign load      = num_valid && !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         neg_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_free) begin
            out_valid_ff <= busy_ff;
         end
         if (emit) begin
            if (neg_ff) begin
               neg_ff <= 1'b0;
            end else if (idx_ff == '0) begin
               busy_ff <= 1'b0;
            end
         end
         if (load) begin
            busy_ff <= 1'b1;
            neg_ff  <= num.neg;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         digits_ff <= num.digits;
         idx_ff    <= num.top;
      end else if (emit && !neg_ff && idx_ff != '0) begin
         idx_ff <= idx_ff - 1'b1;
      end
      if (emit) begin
         if (neg_ff) begin
            out_char_ff <= CHAR_MINUS;
            out_last_ff <= 1'b0;
         end else begin
            out_char_ff <= digit_char(digits_ff[idx_ff]);
            out_last_ff <= (idx_ff == '0);
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_char_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// File: src/integer_radix_to_ascii.sv
// Top level: integer to ASCII text in radix 10, 16 or 8.
// From accept, a number passes the entry register, the dabble stages, the digit
// register and the serializer. The pipeline takes a word every cycle unless stalled by
// back-pressure; the serializer loads a new number only after its last character.
// Synchronous active-high reset clears all valid bits; payload registers are not reset.
module integer_radix_to_ascii import rita_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,  // value
   input  logic [3:0]               req_tuser,  // radix_select[1:0], signed_mode, wide_value
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [7:0]               rsp_tdata,  // text_char
   output logic                     rsp_tlast   // last_char
);

   pipe_type              pipe_ff  [DABBLE_STAGES+1];
   logic [DABBLE_STAGES:0] valid_ff;
   logic [DABBLE_STAGES:0] take;
   pipe_type              entry;
   logic [VALUE_BITS-1:0] value;
   logic [VALUE_BITS-1:0] ext;
   logic                  sbit;
   logic                  neg;
   number_type            fin_in;
   number_type            fin_ff;
   logic                  fin_valid_ff;
   logic                  fin_take;
   logic                  ser_ready;
   logic [MAX_DIGITS*3-1:0] oct_raw;
   logic [MAX_DIGITS*4-1:0] hex_raw;

   // normalize: width mask, sign extension, magnitude
   always_comb begin
      value = req_tdata[VALUE_BITS-1:0];
      sbit  = req_tuser[3] ? value[VALUE_BITS-1] : value[NARROW_BITS-1];
      neg   = req_tuser[2] && sbit;
      for (int i = 0; i < VALUE_BITS; i++) begin
         ext[i] = (req_tuser[3] || i < NARROW_BITS) ? value[i] : neg;
      end
      entry.raw   = neg ? (~ext + VALUE_BITS'(1)) : ext;
      entry.work  = WORK_BITS'(entry.raw);
      entry.bcd   = '0;
      entry.radix = radix_type'(req_tuser[1:0]);
      entry.neg   = neg;
   end

   always_comb begin
      take[DABBLE_STAGES] = !valid_ff[DABBLE_STAGES] || fin_take;
      for (int k = DABBLE_STAGES - 1; k >= 0; k--) begin
         take[k] = !valid_ff[k] || take[k+1];
      end
   end
   assign req_tready = take[0];
   assign fin_take   = !fin_valid_ff || ser_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (take[0]) begin
            valid_ff[0] <= req_tvalid;
         end
         for (int k = 1; k <= DABBLE_STAGES; k++) begin
            if (take[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take[0]) begin
         pipe_ff[0] <= entry;
      end
      for (int k = 1; k <= DABBLE_STAGES; k++) begin
         if (take[k]) begin
            pipe_ff[k] <= dabble_step(pipe_ff[k-1]);
         end
      end
   end

   // digit vector and most significant nonzero digit
   always_comb begin
      oct_raw = (MAX_DIGITS*3)'(pipe_ff[DABBLE_STAGES].raw);
      hex_raw = (MAX_DIGITS*4)'(pipe_ff[DABBLE_STAGES].raw);
      for (int i = 0; i < MAX_DIGITS; i++) begin
         unique case (pipe_ff[DABBLE_STAGES].radix)
            RADIX_HEX: fin_in.digits[i] = (i < HEX_DIGITS) ? hex_raw[i*4 +: 4] : 4'h0;
            RADIX_OCT: fin_in.digits[i] = {1'b0, oct_raw[i*3 +: 3]};
            default:   fin_in.digits[i] = (i < BCD_DIGITS) ?
                                          pipe_ff[DABBLE_STAGES].bcd[(i%BCD_DIGITS)*4 +: 4] : 4'h0;
         endcase
      end
      fin_in.top = '0;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         if (fin_in.digits[i] != 4'h0) begin
            fin_in.top = IDX_BITS'(i);
         end
      end
      fin_in.neg = pipe_ff[DABBLE_STAGES].neg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else if (fin_take) begin
         fin_valid_ff <= valid_ff[DABBLE_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (fin_take) begin
         fin_ff <= fin_in;
      end
   end

   rita_serializer u_ser (
      .clock      (clock),
      .reset      (reset),
      .num_valid  (fin_valid_ff),
      .num        (fin_ff),
      .num_ready  (ser_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: src/rita_checker.sv
// Port-level checker for the integer-to-ASCII converter, bound to the top level.
module rita_checker import rita_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [7:0]               rsp_tdata,
   input logic                     rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp word changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp valid right after reset");

   a_last_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata != CHAR_MINUS)
      else $error("sign marked as last character");

   a_char_set: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata == CHAR_MINUS ||
                     (rsp_tdata >= 8'h30 && rsp_tdata <= 8'h39) ||
                     (rsp_tdata >= 8'h61 && rsp_tdata <= 8'h66))
      else $error("character outside sign and digit set");

endmodule

bind integer_radix_to_ascii rita_checker u_rita_checker (.*);
